// ===== design/olid_pkg.sv =====
// olid_pkg: shared types, constants and address helper for the ordered list unit
// used by olid_ctrl, olid_datapath and ordered_list_insert_delete_dump_unit
// no dependencies
package olid_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = ADDR_W + 1;

   // field widths
   localparam int FUNC_W  = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int CMP_W   = POS_W + 1;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP        = 2'd3;

   // request transaction
   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [VALUE_W-1:0] entry_value;
      logic                      list_empty;
      logic                      last;
      logic                      dropped;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic push_front;
      logic push_back;
      logic set_drop;
      logic shift_init;
      logic shift_step;
      logic shift_end;
      logic idx_clear;
      logic dump_step;
      logic dump_empty;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic del_ok;
      logic shift_done;
      logic empty;
      logic dump_last;
   } dp_status_type;

   // logical index to ring buffer address, head plus index wrapped at capacity
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  idx);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + SUM_W'(idx);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== design/olid_ram.sv =====
// olid_ram: generic single write, single read port ram with registered read data
// no dependencies
module olid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/olid_ctrl.sv =====
// olid_ctrl: command sequencer for the ordered list unit (accept, shift, dump)
// depends on olid_pkg
module olid_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [olid_pkg::FUNC_W-1:0]    func,
   input  olid_pkg::dp_status_type        status,
   output olid_pkg::dp_cmd_type           cmd,
   output logic                           busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DUMP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DUMP;
               case (func)
                  olid_pkg::FUNC_PUSH_FRONT: begin
                     cmd.idx_clear = 1'b1;
                     if (status.full) begin
                        cmd.set_drop = 1'b1;
                     end else begin
                        cmd.push_front = 1'b1;
                     end
                  end
                  olid_pkg::FUNC_PUSH_BACK: begin
                     cmd.idx_clear = 1'b1;
                     if (status.full) begin
                        cmd.set_drop = 1'b1;
                     end else begin
                        cmd.push_back = 1'b1;
                     end
                  end
                  olid_pkg::FUNC_DELETE: begin
                     if (status.del_ok) begin
                        cmd.shift_init = 1'b1;
                        state_in       = ST_SHIFT;
                     end else begin
                        cmd.idx_clear = 1'b1;
                     end
                  end
                  default: begin
                     cmd.idx_clear = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (status.shift_done) begin
               cmd.shift_end = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_DUMP;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_DUMP: begin
            if (status.empty) begin
               cmd.dump_empty = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.dump_step = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/olid_datapath.sv =====
// olid_datapath: ring buffer storage, count, head and index registers, result register
// depends on olid_pkg and olid_ram
module olid_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  olid_pkg::req_type         req_payload,
   input  olid_pkg::dp_cmd_type      cmd,
   output olid_pkg::dp_status_type   status,
   output logic                      rsp_strobe,
   output olid_pkg::rsp_type         rsp_payload
);

   logic [olid_pkg::ADDR_W-1:0]  head_ff, head_in;
   logic [olid_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [olid_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [olid_pkg::ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic                         drop_ff, drop_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_empty_ff, out_empty_in;

   logic [olid_pkg::ADDR_W-1:0]  head_dec;
   logic [olid_pkg::CNT_W-1:0]   idx_inc;
   logic                         ram_wr_en;
   logic [olid_pkg::ADDR_W-1:0]  ram_wr_addr;
   logic [olid_pkg::VALUE_W-1:0] ram_wr_data;
   logic                         ram_rd_en;
   logic [olid_pkg::ADDR_W-1:0]  ram_rd_addr;
   logic [olid_pkg::VALUE_W-1:0] ram_rd_data;

   // status toward the controller
   assign idx_inc = olid_pkg::CNT_W'(idx_ff + olid_pkg::CNT_W'(1));
   always_comb begin
      status.full       = (count_ff == olid_pkg::CNT_W'(olid_pkg::CAPACITY));
      status.del_ok     = ({1'b0, req_payload.position} < olid_pkg::CMP_W'(count_ff));
      status.shift_done = (idx_ff >= count_ff);
      status.empty      = (count_ff == '0);
      status.dump_last  = (idx_inc == count_ff);
   end

   // head moves back one slot on a front insert
   assign head_dec = (head_ff == '0) ? olid_pkg::ADDR_W'(olid_pkg::CAPACITY - 1)
                                     : head_ff - olid_pkg::ADDR_W'(1);

   // ram port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      if (cmd.push_front) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = head_dec;
         ram_wr_data = req_payload.value;
      end else if (cmd.push_back) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = olid_pkg::phys_addr(head_ff, count_ff);
         ram_wr_data = req_payload.value;
      end else if (pend_ff) begin
         ram_wr_en = 1'b1;
      end
      ram_rd_en   = cmd.shift_step | cmd.dump_step;
      ram_rd_addr = olid_pkg::phys_addr(head_ff, idx_ff);
   end

   olid_ram #(
      .WIDTH (olid_pkg::VALUE_W),
      .DEPTH (olid_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values of list control and index registers
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      wr_addr_in = wr_addr_ff;
      drop_in    = drop_ff;
      if (cmd.accept) begin
         drop_in = cmd.set_drop;
      end
      if (cmd.push_front) begin
         head_in  = head_dec;
         count_in = olid_pkg::CNT_W'(count_ff + olid_pkg::CNT_W'(1));
      end else if (cmd.push_back) begin
         count_in = olid_pkg::CNT_W'(count_ff + olid_pkg::CNT_W'(1));
      end else if (cmd.shift_end) begin
         count_in = olid_pkg::CNT_W'(count_ff - olid_pkg::CNT_W'(1));
      end
      // shift pipeline: read source now, write it one slot lower next cycle
      if (cmd.shift_init) begin
         idx_in  = olid_pkg::CNT_W'({1'b0, req_payload.position} + olid_pkg::CMP_W'(1));
         pend_in = 1'b0;
      end else if (cmd.shift_step) begin
         idx_in     = idx_inc;
         pend_in    = 1'b1;
         wr_addr_in = olid_pkg::phys_addr(head_ff,
                                          olid_pkg::CNT_W'(idx_ff - olid_pkg::CNT_W'(1)));
      end else if (cmd.dump_step) begin
         idx_in = idx_inc;
      end else if (cmd.idx_clear) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end
   end

   // result flags line up with the registered ram read
   always_comb begin
      out_valid_in = cmd.dump_step | cmd.dump_empty;
      out_last_in  = cmd.dump_empty | (cmd.dump_step & status.dump_last);
      out_empty_in = cmd.dump_empty;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_addr_ff   <= wr_addr_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   // result transaction
   assign rsp_strobe = out_valid_ff;
   always_comb begin
      rsp_payload.entry_value = out_empty_ff ? '0 : ram_rd_data;
      rsp_payload.list_empty  = out_empty_ff;
      rsp_payload.last        = out_last_ff;
      rsp_payload.dropped     = drop_ff;
   end

`ifndef SYNTHESIS
   // a dump always closes before the next one can produce its first item
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |=> !out_valid_ff)
      else $error("result strobe directly after last item");

   // the stored count never goes past capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
      else $error("entry count above capacity");

   // shifting only writes while a delete is being worked off
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.shift_step))
      else $error("shift write without a preceding shift read");
`endif

endmodule

// ===== design/ordered_list_insert_delete_dump_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit values kept in a ring buffer RAM.
// A command is taken when start is high and busy is low. It inserts at the front or
// back in its accept cycle, or, for a delete, moves the later entries down one place in
// the shift state, one RAM read and write per cycle. Then the whole list is dumped front
// to back, one result per cycle on rsp_strobe, the last result marked; an empty list
// gives one result flagged empty. After its dump step, each result value comes from the
// registered RAM read and its flags from the result registers. Shift and dump each go
// one entry at a time through the single read port of the RAM.
// The next command may start in the cycle of the last result.
// The receiver cannot stall: every result is shown for exactly one cycle.
// depends on olid_pkg, olid_ctrl, olid_datapath
module ordered_list_insert_delete_dump_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  olid_pkg::req_type   req_payload,
   output logic                rsp_strobe,
   output olid_pkg::rsp_type   rsp_payload
);

   olid_pkg::dp_cmd_type    dp_cmd;
   olid_pkg::dp_status_type dp_status;

   // sequencer
   olid_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_payload.func),
      .status (dp_status),
      .cmd    (dp_cmd),
      .busy   (busy)
   );

   // storage and result path
   olid_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // an accepted transaction always occupies the unit on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit idle right after accepting a transaction");

   // a result follows a cycle of dump work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // an empty list dump is a single, final item
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.list_empty |-> rsp_payload.last)
      else $error("empty dump item not marked last");
`endif

endmodule

// ===== tb/ordered_list_insert_delete_dump_unit_tb.sv =====
// self-checking testbench for ordered_list_insert_delete_dump_unit: directed table,
// fill to full, then random grow/shrink traffic checked against a queue-based list model
// depends on olid_pkg and ordered_list_insert_delete_dump_unit
module ordered_list_insert_delete_dump_unit_tb;

   localparam int NUM_DIR    = 16;
   localparam int NUM_RANDOM = 20;
   localparam int REQ_W      = $bits(olid_pkg::req_type);
   localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam olid_pkg::rsp_type EMPTY_DUMP = {32'sh0, 1'b1, 1'b1, 1'b0};

   // one row of the directed table, with an optional hand-written single-item dump
   typedef struct packed {
      olid_pkg::req_type cmd;
      logic              typed;
      olid_pkg::rsp_type dump;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   olid_pkg::req_type req_payload;
   logic              rsp_strobe;
   olid_pkg::rsp_type rsp_payload;

   // list model and the dump items still owed by the block
   logic signed [olid_pkg::VALUE_W-1:0] shadow_list[$];
   olid_pkg::rsp_type                   dump_expect[$];

   stim_row_type dir_tab[NUM_DIR];
   int err_count   = 0;
   int cmd_count   = 0;
   int rsp_checked = 0;
   int drop_count  = 0;
   int peak_fill   = 0;

   ordered_list_insert_delete_dump_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("timeout at %0t, %0d dump items outstanding", $time, dump_expect.size());
      $display("ordered_list_insert_delete_dump_unit: mismatch");
      $finish;
   end

   // update the list model for one accepted command and queue its dump
   task automatic apply_list_cmd(input olid_pkg::req_type cmd, input logic typed,
                                 input olid_pkg::rsp_type typed_dump);
      logic              drop;
      olid_pkg::rsp_type item;
      drop = 1'b0;
      case (cmd.func)
         olid_pkg::FUNC_PUSH_FRONT, olid_pkg::FUNC_PUSH_BACK: begin
            if (shadow_list.size() >= olid_pkg::CAPACITY) begin
               drop = 1'b1;
            end else if (cmd.func == olid_pkg::FUNC_PUSH_FRONT) begin
               shadow_list.push_front(cmd.value);
            end else begin
               shadow_list.push_back(cmd.value);
            end
         end
         olid_pkg::FUNC_DELETE: begin
            if (int'(cmd.position) < shadow_list.size()) begin
               shadow_list.delete(int'(cmd.position));
            end
         end
         default: ;
      endcase
      cmd_count++;
      if (drop) drop_count++;
      if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();

      if (typed) begin
         dump_expect.push_back(typed_dump);
      end else if (shadow_list.size() == 0) begin
         item.entry_value = '0;
         item.list_empty  = 1'b1;
         item.last        = 1'b1;
         item.dropped     = drop;
         dump_expect.push_back(item);
      end else begin
         foreach (shadow_list[k]) begin
            item.entry_value = shadow_list[k];
            item.list_empty  = 1'b0;
            item.last        = (k == shadow_list.size() - 1);
            item.dropped     = drop;
            dump_expect.push_back(item);
         end
      end
   endtask

   // present a command and hold it until the block takes it
   task automatic issue_cmd(input olid_pkg::req_type cmd, input logic typed,
                            input olid_pkg::rsp_type typed_dump);
      start       <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (busy);
      apply_list_cmd(cmd, typed, typed_dump);
   endtask

   // drop start and put junk on the payload for an idle gap, none when n is zero
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start       <= 1'b0;
         req_payload <= olid_pkg::req_type'(REQ_W'({$urandom, $urandom}));
         repeat (n) @(posedge clock);
      end
   endtask

   // sender pause until every queued dump item has come out
   task automatic wait_dump_drained();
      idle_cycles(1);
      while (dump_expect.size() != 0) @(posedge clock);
   endtask

   // mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int pick_gap(input logic burst);
      int r;
      r = $urandom_range(99);
      if (burst || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [olid_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // random command; grow_pct sets the share of inserts
   function automatic olid_pkg::req_type pick_cmd(input int grow_pct);
      olid_pkg::req_type cmd;
      int                r;
      r = $urandom_range(99);
      cmd.value    = pick_value();
      cmd.position = olid_pkg::POS_W'($urandom_range(127));
      if (r < grow_pct) begin
         cmd.func = $urandom_range(1) ? olid_pkg::FUNC_PUSH_BACK : olid_pkg::FUNC_PUSH_FRONT;
      end else if (r < 93) begin
         cmd.func = olid_pkg::FUNC_DELETE;
         if (shadow_list.size() != 0 && $urandom_range(99) < 85) begin
            cmd.position = olid_pkg::POS_W'($urandom_range(shadow_list.size() - 1));
         end
      end else begin
         cmd.func = olid_pkg::FUNC_NOP;
      end
      return cmd;
   endfunction

   // compare each strobed result with the oldest queued dump item
   always @(posedge clock) begin : dump_check
      olid_pkg::rsp_type want;
      logic              bad;
      if (!reset && rsp_strobe) begin
         if (dump_expect.size() == 0) begin
            err_count++;
            $display("%0t: expected no result, actual value=%0d empty=%b last=%b dropped=%b",
                     $time, rsp_payload.entry_value, rsp_payload.list_empty,
                     rsp_payload.last, rsp_payload.dropped);
         end else begin
            want = dump_expect.pop_front();
            rsp_checked++;
            // entry value carries nothing on an empty dump
            bad = (rsp_payload.list_empty !== want.list_empty) ||
                  (rsp_payload.last !== want.last) ||
                  (rsp_payload.dropped !== want.dropped) ||
                  (!want.list_empty && rsp_payload.entry_value !== want.entry_value);
            if (bad) begin
               err_count++;
               $display("%0t: expected value=%0d empty=%b last=%b dropped=%b,",
                        $time, want.entry_value, want.list_empty, want.last,
                        want.dropped);
               $display("   actual value=%0d empty=%b last=%b dropped=%b",
                        rsp_payload.entry_value, rsp_payload.list_empty,
                        rsp_payload.last, rsp_payload.dropped);
            end
         end
      end
   end

   // stimulus
   initial begin
      olid_pkg::req_type cmd;
      olid_pkg::rsp_type no_dump;
      logic              burst;

      no_dump = '0;
      start       <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;

      // directed table: empty-list cases, extremes, ignored fields, deletes at each end
      dir_tab[0]  = {{olid_pkg::FUNC_NOP, 32'sh0, 7'd0}, 1'b1, EMPTY_DUMP};
      dir_tab[1]  = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd0}, 1'b1, EMPTY_DUMP};
      dir_tab[2]  = {{olid_pkg::FUNC_DELETE, VAL_MAX, 7'd127}, 1'b1, EMPTY_DUMP};
      dir_tab[3]  = {{olid_pkg::FUNC_PUSH_FRONT, VAL_MIN, 7'd0}, 1'b1,
                     {VAL_MIN, 1'b0, 1'b1, 1'b0}};
      dir_tab[4]  = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd0}, 1'b1, EMPTY_DUMP};
      dir_tab[5]  = {{olid_pkg::FUNC_PUSH_BACK, VAL_MAX, 7'd127}, 1'b1,
                     {VAL_MAX, 1'b0, 1'b1, 1'b0}};
      dir_tab[6]  = {{olid_pkg::FUNC_PUSH_FRONT, -32'sd1, 7'd0}, 1'b0, no_dump};
      dir_tab[7]  = {{olid_pkg::FUNC_PUSH_BACK, 32'sh0, 7'd0}, 1'b0, no_dump};
      dir_tab[8]  = {{olid_pkg::FUNC_PUSH_FRONT, 32'sh5555_5555, 7'h7f}, 1'b0, no_dump};
      dir_tab[9]  = {{olid_pkg::FUNC_PUSH_BACK, 32'shaaaa_aaaa, 7'h55}, 1'b0, no_dump};
      dir_tab[10] = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd1}, 1'b0, no_dump};
      dir_tab[11] = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd3}, 1'b0, no_dump};
      dir_tab[12] = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd3}, 1'b0, no_dump};
      dir_tab[13] = {{olid_pkg::FUNC_DELETE, -32'sd1, 7'd127}, 1'b0, no_dump};
      dir_tab[14] = {{olid_pkg::FUNC_NOP, -32'sd1, 7'h2a}, 1'b0, no_dump};
      dir_tab[15] = {{olid_pkg::FUNC_DELETE, 32'sh0, 7'd0}, 1'b0, no_dump};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         issue_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].dump);
         idle_cycles(pick_gap(1'b0));
      end
      wait_dump_drained();

      // fill to capacity, then inserts that must be refused and a delete of the last entry
      while (shadow_list.size() < olid_pkg::CAPACITY) begin
         cmd.func     = $urandom_range(1) ? olid_pkg::FUNC_PUSH_BACK
                                          : olid_pkg::FUNC_PUSH_FRONT;
         cmd.value    = pick_value();
         cmd.position = olid_pkg::POS_W'($urandom_range(127));
         issue_cmd(cmd, 1'b0, no_dump);
         idle_cycles(pick_gap(1'b0));
      end
      cmd = {olid_pkg::FUNC_PUSH_FRONT, VAL_MAX, 7'd0};
      issue_cmd(cmd, 1'b0, no_dump);
      cmd = {olid_pkg::FUNC_PUSH_BACK, VAL_MIN, 7'd127};
      issue_cmd(cmd, 1'b0, no_dump);
      cmd = {olid_pkg::FUNC_DELETE, 32'sh0, 7'(olid_pkg::CAPACITY - 1)};
      issue_cmd(cmd, 1'b0, no_dump);
      wait_dump_drained();

      // random traffic, alternating shrink and grow phases, with back-to-back bursts
      burst = 1'b0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 5 == 0) burst = ($urandom_range(2) == 0);
         issue_cmd(pick_cmd(((n / 5) % 2 == 0) ? 20 : 70), 1'b0, no_dump);
         idle_cycles(pick_gap(burst));
      end
      cmd = {olid_pkg::FUNC_NOP, 32'sh0, 7'd0};
      issue_cmd(cmd, 1'b0, no_dump);

      wait_dump_drained();
      repeat (80) @(posedge clock);

      $display("%0d commands sent, %0d list items checked, %0d refused inserts",
               cmd_count, rsp_checked, drop_count);
      $display("list grew to %0d of %0d entries, empty and full lists both dumped",
               peak_fill, olid_pkg::CAPACITY);
      if (err_count == 0 && dump_expect.size() == 0) begin
         $display("ordered_list_insert_delete_dump_unit: match");
      end else begin
         $display("ordered_list_insert_delete_dump_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/olid_pkg.sv
design/olid_ram.sv
design/olid_ctrl.sv
design/olid_datapath.sv
design/ordered_list_insert_delete_dump_unit.sv
tb/ordered_list_insert_delete_dump_unit_tb.sv
